@@ rtl/sil_pkg.sv @@
// shared constants, types and codes for the sorted insertion list
`timescale 1ns / 1ps
package sil_pkg;

  // list depth and field widths
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned KIND_W   = 2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_VALUE = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_FULL  = 2'd2
  } kind_e;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_e;

  // broadcast from the controller to the whole chain
  typedef struct packed {
    cell_op_e op;
    value_t   ins;
  } cell_ctrl_t;

  // controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FLUSH = 1'b1
  } state_e;

endpackage

@@ rtl/sil_cell.sv @@
// one compare-and-shift cell of the sorted chain
`timescale 1ns / 1ps
module sil_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sil_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_gt_i,
  input  logic                prev_vld_i,
  input  sil_pkg::value_t     prev_val_i,
  input  logic                next_vld_i,
  input  sil_pkg::value_t     next_val_i,
  output logic                gt_o,
  output logic                vld_o,
  output sil_pkg::value_t     val_o
);
  import sil_pkg::*;

  logic   vld_q, vld_d;
  value_t val_q, val_d;

  // an empty cell counts as greater than anything
  assign gt_o = !vld_q || (val_q > ctrl_i.ins);

  // next contents: hold, make room for the new item, or move towards the head
  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        vld_d = prev_vld_i;
        if (gt_o) begin
          val_d = prev_gt_i ? prev_val_i : ctrl_i.ins;
        end
      end
      OP_SHIFT: begin
        vld_d = next_vld_i;
        val_d = next_val_i;
      end
      default: begin
        vld_d = vld_q;
        val_d = val_q;
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stored value
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign vld_o = vld_q;
  assign val_o = val_q;

endmodule

@@ rtl/sorted_insertion_list.sv @@
// top level of the sorted insertion list: controller, cell chain and result register
//
//  channel  | signals                           | direction | handshake
//  ---------+-----------------------------------+-----------+---------------------------
//  command  | cmd_i, value_i                    | in        | start_i high, busy_o low
//  result   | out_value_o, kind_o, last_o       | out       | strobe_o, one cycle, no stall
//
// On an insert every cell compares at once and the chain opens a gap.
// A flush of n items keeps busy_o high while the chain shifts one item per cycle
// towards the head; each result leaves the result register in the cycle after its shift.
// Dropped inserts and empty flushes report in the cycle after acceptance.
// Reset empties the chain at once through the per-cell occupancy flags.
`timescale 1ns / 1ps
module sorted_insertion_list (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            cmd_i,
  input  sil_pkg::value_t value_i,
  output logic            strobe_o,
  output sil_pkg::value_t out_value_o,
  output logic [1:0]      kind_o,
  output logic            last_o
);
  import sil_pkg::*;

  state_e     state_q, state_d;
  cell_ctrl_t ctrl;
  logic       accept;

  logic   cell_gt  [CAPACITY];
  logic   cell_vld [CAPACITY];
  value_t cell_val [CAPACITY];
  logic [CAPACITY-1:0] vld_vec;

  logic   strobe_q, strobe_d;
  logic   last_q, last_d;
  kind_e  kind_q, kind_d;
  value_t oval_q, oval_d;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q == ST_FLUSH);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   p_gt, p_vld, n_vld;
    value_t p_val, n_val;
    if (i == 0) begin : g_head
      assign p_gt  = 1'b0;
      assign p_vld = 1'b1;
      assign p_val = '0;
    end else begin : g_mid
      assign p_gt  = cell_gt[i-1];
      assign p_vld = cell_vld[i-1];
      assign p_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign n_vld = 1'b0;
      assign n_val = '0;
    end else begin : g_body
      assign n_vld = cell_vld[i+1];
      assign n_val = cell_val[i+1];
    end

    sil_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_gt_i  (p_gt),
      .prev_vld_i (p_vld),
      .prev_val_i (p_val),
      .next_vld_i (n_vld),
      .next_val_i (n_val),
      .gt_o       (cell_gt[i]),
      .vld_o      (cell_vld[i]),
      .val_o      (cell_val[i])
    );

    assign vld_vec[i] = cell_vld[i];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_FLUSH) && cell_vld[0]) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!cell_vld[1]) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // chain control and result
  always_comb begin
    ctrl.op  = OP_HOLD;
    ctrl.ins = value_i;
    strobe_d = 1'b0;
    oval_d   = '0;
    kind_d   = KIND_VALUE;
    last_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_INSERT) begin
            if (cell_vld[CAPACITY-1]) begin
              strobe_d = 1'b1;
              kind_d   = KIND_FULL;
              last_d   = 1'b1;
            end else begin
              ctrl.op = OP_INSERT;
            end
          end else if (!cell_vld[0]) begin
            strobe_d = 1'b1;
            kind_d   = KIND_EMPTY;
            last_d   = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        ctrl.op  = OP_SHIFT;
        strobe_d = 1'b1;
        oval_d   = cell_val[0];
        kind_d   = KIND_VALUE;
        last_d   = !cell_vld[1];
      end
      default: ctrl.op = OP_HOLD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    oval_q <= oval_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign strobe_o    = strobe_q;
  assign out_value_o = oval_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

  // occupancy always fills from the head
  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec + CAPACITY'(1)) & vld_vec) == '0)
    else $error("chain occupancy has a gap");

  // a flush only runs while the head holds an item
  a_flush_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> cell_vld[0])
    else $error("flush running on an empty chain");

  // reports other than sorted values are single and final
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (kind_o != KIND_VALUE)) |-> last_o)
    else $error("report without last");

  // the final flushed item leaves the chain empty
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o && (kind_o == KIND_VALUE)) |-> !cell_vld[0])
    else $error("chain not empty after flush");

endmodule

@@ bench/tb.sv @@
// self-checking bench for the sorted insertion list: queued command driver, result monitor
`timescale 1ns / 1ps
module tb;
  import sil_pkg::*;

  localparam int unsigned ITEM_TARGET = 210;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct {
    cmd_e        cmd;
    value_t      value;
    int unsigned gap;
  } list_cmd_t;

  typedef struct {
    value_t value;
    kind_e  kind;
    logic   last;
  } list_report_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   cmd_i = 1'b0;
  value_t value_i = '0;
  logic   busy_o;
  logic   strobe_o;
  value_t out_value_o;
  logic [1:0] kind_o;
  logic   last_o;

  list_cmd_t    pending_cmds[$];
  list_report_t due_reports[$];
  value_t       sorted_copy[$];
  list_cmd_t    next_cmd;
  logic         took = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  mismatches = 0;
  bit           burst_mode = 1'b0;

  sorted_insertion_list DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .out_value_o(out_value_o),
    .kind_o     (kind_o),
    .last_o     (last_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // predict the reports of one accepted command and update the sorted copy
  task automatic sort_into_list(input cmd_e cmd, input value_t v);
    int unsigned pos;
    list_report_t rep;
    if (cmd == CMD_INSERT) begin
      if (sorted_copy.size() >= CAPACITY) begin
        rep.value = '0;
        rep.kind  = KIND_FULL;
        rep.last  = 1'b1;
        due_reports.push_back(rep);
      end else begin
        pos = 0;
        while (pos < sorted_copy.size() && !(sorted_copy[pos] > v)) pos++;
        sorted_copy.insert(pos, v);
      end
    end else if (sorted_copy.size() == 0) begin
      rep.value = '0;
      rep.kind  = KIND_EMPTY;
      rep.last  = 1'b1;
      due_reports.push_back(rep);
    end else begin
      for (int i = 0; i < sorted_copy.size(); i++) begin
        rep.value = sorted_copy[i];
        rep.kind  = KIND_VALUE;
        rep.last  = (i == sorted_copy.size() - 1);
        due_reports.push_back(rep);
      end
      sorted_copy.delete();
    end
  endtask

  // pause after an item: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // values: clustered for duplicates, edge values, or the full range
  function automatic value_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return value_t'($signed($urandom_range(0, 16)) - 8);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        default: return 32'shFFFF_FFFF;
      endcase
    end
    return value_t'($urandom);
  endfunction

  task automatic add_cmd(input cmd_e cmd, input value_t v);
    list_cmd_t c;
    c.cmd   = cmd;
    c.value = v;
    c.gap   = pick_gap();
    pending_cmds.push_back(c);
  endtask

  // command driver: changes inputs at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !took) begin
      // hold the item until it is taken
    end else if (gap_left != 0) begin
      start_i  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() != 0) begin
      next_cmd = pending_cmds.pop_front();
      cmd_i    <= next_cmd.cmd;
      value_i  <= next_cmd.value;
      start_i  <= 1'b1;
      gap_left <= next_cmd.gap;
    end else begin
      start_i <= 1'b0;
    end
  end

  // result monitor and acceptance tracking at the rising edge
  always @(posedge clk_i) begin
    list_report_t exp;
    if (rst_ni) begin
      took <= start_i && !busy_o;
      if (strobe_o || (start_i && !busy_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      // results belong to earlier items, so check them before predicting new ones
      if (strobe_o) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: value %0d kind %0d last %0b",
                   $realtime, out_value_o, kind_o, last_o);
        end else begin
          exp = due_reports.pop_front();
          if (out_value_o !== exp.value) begin
            mismatches++;
            $display("%0t: out_value expected %0d actual %0d", $realtime, exp.value,
                     out_value_o);
          end
          if (kind_o !== exp.kind) begin
            mismatches++;
            $display("%0t: kind expected %0d actual %0d", $realtime, exp.kind, kind_o);
          end
          if (last_o !== exp.last) begin
            mismatches++;
            $display("%0t: last expected %0b actual %0b", $realtime, exp.last, last_o);
          end
        end
      end
      if (start_i && !busy_o) sort_into_list(cmd_e'(cmd_i), value_i);
    end else begin
      took <= 1'b0;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned queued;
    int unsigned n_ins;
    bit timed_out;

    // directed: empty flush, edge values, front, back and middle inserts, duplicates
    add_cmd(CMD_FLUSH, 32'sh1234_5678);
    add_cmd(CMD_INSERT, 32'sh0000_0000);
    add_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    add_cmd(CMD_INSERT, 32'sh8000_0000);
    add_cmd(CMD_INSERT, -32'sd1);
    add_cmd(CMD_INSERT, 32'sd1);
    add_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    add_cmd(CMD_INSERT, 32'sh8000_0000);
    add_cmd(CMD_INSERT, 32'sd5);
    add_cmd(CMD_INSERT, 32'sd0);
    add_cmd(CMD_INSERT, -32'sd5);
    add_cmd(CMD_FLUSH, 32'shFFFF_FFFF);
    add_cmd(CMD_FLUSH, 32'sh0000_0000);
    add_cmd(CMD_INSERT, 32'sh5555_5555);
    add_cmd(CMD_INSERT, 32'shAAAA_AAAA);
    add_cmd(CMD_FLUSH, 32'shAAAA_AAAA);

    // random: insert runs closed by a flush, the first one overfilling the list
    queued = 0;
    while (pending_cmds.size() < ITEM_TARGET) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if (queued == 0 || $urandom_range(0, 99) < 15) n_ins = $urandom_range(CAPACITY - 2,
                                                                             CAPACITY + 4);
      else n_ins = $urandom_range(0, 8);
      if (queued == 0) n_ins = CAPACITY + 2;
      repeat (n_ins) add_cmd(CMD_INSERT, pick_value());
      add_cmd(CMD_FLUSH, value_t'($urandom));
      queued += n_ins + 1;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    timed_out = 1'b0;
    while (!(pending_cmds.size() == 0 && !start_i && due_reports.size() == 0) &&
           stall_cycles < STALL_LIMIT)
      @(posedge clk_i);
    if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    else repeat (DRAIN_CYCLES) @(posedge clk_i);
    #1;
    if (!timed_out && mismatches == 0 && due_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
